### rtl/crdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crdg_pkg
// shared widths, codes and payload types of the camera ray direction generator
// ----------------------------------------------------------------------------
package crdg_pkg;

    localparam int COMP_W    = 20;
    localparam int VEC_W     = 3 * COMP_W;
    localparam int PIX_W     = 10;
    localparam int PXW       = PIX_W + 1;
    localparam int NORM_BITS = 30;
    localparam int FRAC_BITS = 14;
    localparam int ONE_Q14   = 1 << FRAC_BITS;
    localparam int SQ_W      = 2 * NORM_BITS;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int DVD_W     = NORM_BITS + FRAC_BITS + 1;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int DIR_W     = 16;
    localparam int LANE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 3 * DIR_W;

    localparam logic [LANE_W-1:0] LANE_FINAL = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORNER = 2'd0,
        CFG_RIGHT  = 2'd1,
        CFG_DOWN   = 2'd2
    } t_cfg_idx;

    typedef logic [NORM_BITS-1:0] t_mag;

    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic              last;
    } t_tag;

    typedef struct packed {
        t_tag       tag;
        logic       zero;
        logic [2:0] neg;
    } t_side;

    typedef struct packed {
        t_side      side;
        t_mag [2:0] mag;
    } t_carry;

endpackage

### rtl/crdg_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crdg_expand
// input register that issues one ray per cycle while i_en is high, four lanes for a quad
// ----------------------------------------------------------------------------
module crdg_expand import crdg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_quad,
    input  logic [PIX_W-1:0] i_col,
    input  logic [PIX_W-1:0] i_row,
    output logic             o_valid,
    output logic [PXW-1:0]   o_px,
    output logic [PXW-1:0]   o_py,
    output t_tag             o_tag
);

    logic              r_valid;
    logic              r_quad;
    logic [PIX_W-1:0]  r_col;
    logic [PIX_W-1:0]  r_row;
    logic [LANE_W-1:0] r_lane;
    logic              n_last;
    logic              n_take;

    assign n_last  = !r_quad || (r_lane == LANE_FINAL);
    assign o_ready = !r_valid || (i_en && n_last);
    assign n_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lane  <= '0;
        end else if (n_take) begin
            r_valid <= 1'b1;
            r_lane  <= '0;
        end else if (r_valid && i_en) begin
            if (n_last) begin
                r_valid <= 1'b0;
            end else begin
                r_lane <= r_lane + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take) begin
            r_quad <= i_quad;
            r_col  <= i_col;
            r_row  <= i_row;
        end
    end

    // quad order: (x+1,y+1), (x,y+1), (x+1,y), (x,y)
    assign o_valid  = r_valid;
    assign o_px     = {1'b0, r_col} + PXW'(r_quad && !r_lane[0]);
    assign o_py     = {1'b0, r_row} + PXW'(r_quad && !r_lane[1]);
    assign o_tag.lane = r_lane;
    assign o_tag.last = n_last;

    a_lane_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_en && !n_last |=> r_valid && (r_lane == $past(r_lane) + 1'b1))
        else $error("quad lane did not advance");

    a_quad_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !n_last |-> !o_ready)
        else $error("input taken while a quad is still issuing");

endmodule

### rtl/crdg_vec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crdg_vec
// image-plane vector, magnitude normalization and sum of squares
// ----------------------------------------------------------------------------
module crdg_vec import crdg_pkg::*; #(
    parameter int FRAME_COLS = 1024,
    parameter int FRAME_ROWS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [PXW-1:0]   i_px,
    input  logic [PXW-1:0]   i_py,
    input  t_tag             i_tag,
    input  logic [VEC_W-1:0] i_corner,
    input  logic [VEC_W-1:0] i_right,
    input  logic [VEC_W-1:0] i_down,
    output logic             o_valid,
    output logic [SUM_W-1:0] o_sum,
    output t_carry           o_carry
);

    localparam int CB  = $clog2(FRAME_COLS + 1);
    localparam int RB  = $clog2(FRAME_ROWS + 1);
    localparam int KB  = CB + RB;
    localparam int NW  = PXW + KB + COMP_W + 2;
    localparam int MW  = NW - 1;
    localparam int LW  = $clog2(MW + 1);
    localparam int PRW = COMP_W + PXW + 1;
    localparam int PCW = COMP_W + KB + 1;
    localparam int MRW = PRW + RB + 1;
    localparam int MDW = PRW + CB + 1;
    localparam int GRP = 8;
    localparam int GLW = $clog2(GRP + 1);
    localparam int G   = (MW + GRP - 1) / GRP;
    localparam int DEPTH = 10;

    localparam logic signed [KB:0] K_CR = (KB + 1)'(FRAME_COLS * FRAME_ROWS);
    localparam logic signed [RB:0] K_R  = (RB + 1)'(FRAME_ROWS);
    localparam logic signed [CB:0] K_C  = (CB + 1)'(FRAME_COLS);

    logic [DEPTH-1:0] r_vld;
    t_tag             r_tag [7];

    logic signed [COMP_W-1:0] n_c [3];
    logic signed [COMP_W-1:0] n_r [3];
    logic signed [COMP_W-1:0] n_d [3];
    logic signed [PCW-1:0]    n_pc [3];
    logic signed [PRW-1:0]    n_pr [3];
    logic signed [PRW-1:0]    n_pd [3];

    logic signed [PCW-1:0] r1_pc [3];
    logic signed [PRW-1:0] r1_pr [3];
    logic signed [PRW-1:0] r1_pd [3];
    logic signed [PCW-1:0] r2_pc [3];
    logic signed [MRW-1:0] r2_mr [3];
    logic signed [MDW-1:0] r2_md [3];
    logic signed [NW-1:0]  r3_n  [3];
    logic [MW-1:0]         r4_mag [3];
    logic [2:0]            r4_neg;
    logic [MW-1:0]         n_max;
    logic [MW-1:0]         r5_mag [3];
    logic [MW-1:0]         r5_max;
    logic [2:0]            r5_neg;
    logic [G*GRP-1:0]      n_maxp;
    logic [GLW-1:0]        n_glen [G];
    logic [GLW-1:0]        r6_glen [G];
    logic [MW-1:0]         r6_mag [3];
    logic [2:0]            r6_neg;
    logic                  r6_zero;
    logic [LW-1:0]         n_len;
    logic [LW-1:0]         r7_len;
    logic [MW-1:0]         r7_mag [3];
    logic [2:0]            r7_neg;
    logic                  r7_zero;
    logic [MW+NORM_BITS-1:0] n_wide [3];
    t_carry                r8_car;
    logic [SQ_W-1:0]       r9_sq [3];
    t_carry                r9_car;
    logic [SUM_W-1:0]      r10_sum;
    t_carry                r10_car;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < 7; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c[i]  = $signed(i_corner[i*COMP_W +: COMP_W]);
            n_r[i]  = $signed(i_right[i*COMP_W +: COMP_W]);
            n_d[i]  = $signed(i_down[i*COMP_W +: COMP_W]);
            n_pc[i] = PCW'(n_c[i]) * PCW'(K_CR);
            n_pr[i] = PRW'(n_r[i]) * PRW'($signed({1'b0, i_px}));
            n_pd[i] = PRW'(n_d[i]) * PRW'($signed({1'b0, i_py}));
        end
    end

    always_comb begin
        n_max = r4_mag[0];
        if (r4_mag[1] > n_max) begin
            n_max = r4_mag[1];
        end
        if (r4_mag[2] > n_max) begin
            n_max = r4_mag[2];
        end
    end

    always_comb begin
        n_maxp = (G*GRP)'(r5_max);
        for (int g = 0; g < G; g++) begin
            n_glen[g] = '0;
            for (int b = 0; b < GRP; b++) begin
                if (n_maxp[g*GRP + b]) begin
                    n_glen[g] = GLW'(b + 1);
                end
            end
        end
    end

    always_comb begin
        n_len = '0;
        for (int g = 0; g < G; g++) begin
            if (r6_glen[g] != '0) begin
                n_len = LW'(g * GRP) + LW'(r6_glen[g]);
            end
        end
    end

    // floor(mag * 2^30 / 2^len): right shift truncates, left shift appends zeros
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_wide[i] = {r7_mag[i], {NORM_BITS{1'b0}}} >> r7_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_pc[i]  <= n_pc[i];
                r1_pr[i]  <= n_pr[i];
                r1_pd[i]  <= n_pd[i];
                r2_pc[i]  <= r1_pc[i];
                r2_mr[i]  <= MRW'(r1_pr[i]) * MRW'(K_R);
                r2_md[i]  <= MDW'(r1_pd[i]) * MDW'(K_C);
                r3_n[i]   <= NW'(r2_pc[i]) + NW'(r2_mr[i]) + NW'(r2_md[i]);
                r4_neg[i] <= r3_n[i][NW-1];
                r4_mag[i] <= r3_n[i][NW-1] ? MW'(-r3_n[i]) : MW'(r3_n[i]);
                r5_mag[i] <= r4_mag[i];
                r6_mag[i] <= r5_mag[i];
                r7_mag[i] <= r6_mag[i];
                r8_car.mag[i] <= n_wide[i][NORM_BITS-1:0];
                r9_sq[i]  <= SQ_W'(r8_car.mag[i]) * SQ_W'(r8_car.mag[i]);
            end
            r5_max  <= n_max;
            r5_neg  <= r4_neg;
            r6_glen <= n_glen;
            r6_neg  <= r5_neg;
            r6_zero <= (r5_max == '0);
            r7_len  <= n_len;
            r7_neg  <= r6_neg;
            r7_zero <= r6_zero;
            r8_car.side.tag  <= r_tag[6];
            r8_car.side.zero <= r7_zero;
            r8_car.side.neg  <= r7_neg;
            r9_car  <= r8_car;
            r10_sum <= SUM_W'(r9_sq[0]) + SUM_W'(r9_sq[1]) + SUM_W'(r9_sq[2]);
            r10_car <= r9_car;
        end
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_sum   = r10_sum;
    assign o_carry = r10_car;

endmodule

### rtl/crdg_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crdg_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module crdg_sqrt import crdg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SUM_W-1:0]  i_sum,
    input  t_carry            i_carry,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_carry            o_carry
);

    logic              r_vld  [ROOT_W];
    logic [SUM_W-1:0]  r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    t_carry            r_car  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        localparam int K = ROOT_W - 1 - s;

        logic              w_vld_in;
        logic [SUM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        t_carry            w_car_in;
        logic [SUM_W-1:0]  w_trial;
        logic              w_fit;

        if (s == 0) begin : g_first
            always_comb begin
                w_vld_in  = i_valid;
                w_rem_in  = i_sum;
                w_root_in = '0;
                w_car_in  = i_carry;
            end
        end else begin : g_next
            always_comb begin
                w_vld_in  = r_vld[s-1];
                w_rem_in  = r_rem[s-1];
                w_root_in = r_root[s-1];
                w_car_in  = r_car[s-1];
            end
        end

        // (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k)
        assign w_trial = (SUM_W'(w_root_in) << (K + 1)) | (SUM_W'(1) << (2 * K));
        assign w_fit   = (w_rem_in >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_car[s]  <= w_car_in;
                r_root[s] <= w_fit ? (w_root_in | (ROOT_W'(1) << K)) : w_root_in;
            end
        end

        if (s < ROOT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_fit ? (w_rem_in - w_trial) : w_rem_in;
                end
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_carry = r_car[ROOT_W-1];

endmodule

### rtl/crdg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crdg_div
// rounded division of the three magnitudes by the root, one bit per stage
// ----------------------------------------------------------------------------
module crdg_div import crdg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [ROOT_W-1:0]     i_root,
    input  t_carry                i_carry,
    output logic                  o_valid,
    output logic [2:0][DIR_W-1:0] o_dir,
    output t_tag                  o_tag
);

    logic              r_p_vld;
    logic [DVD_W-1:0]  r_p_dvd [3];
    logic [ROOT_W-1:0] r_p_div;
    t_side             r_p_side;

    logic              r_vld  [QUO_W];
    logic [DVD_W-1:0]  r_rem  [QUO_W-1][3];
    logic [QUO_W-1:0]  r_quo  [QUO_W][3];
    logic [ROOT_W-1:0] r_div  [QUO_W-1];
    t_side             r_side [QUO_W];

    logic                  r_o_vld;
    logic [2:0][DIR_W-1:0] r_o_dir;
    t_tag                  r_o_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p_dvd[i] <= (DVD_W'(i_carry.mag[i]) << FRAC_BITS) + DVD_W'(i_root >> 1);
            end
            r_p_div  <= i_root;
            r_p_side <= i_carry.side;
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        localparam int K = QUO_W - 1 - s;

        logic              w_vld_in;
        logic [DVD_W-1:0]  w_rem_in [3];
        logic [QUO_W-1:0]  w_quo_in [3];
        logic [ROOT_W-1:0] w_div_in;
        t_side             w_side_in;
        logic [DVD_W-1:0]  w_trial;
        logic [2:0]        w_fit;

        if (s == 0) begin : g_first
            always_comb begin
                w_vld_in  = r_p_vld;
                w_div_in  = r_p_div;
                w_side_in = r_p_side;
                for (int i = 0; i < 3; i++) begin
                    w_rem_in[i] = r_p_dvd[i];
                    w_quo_in[i] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                w_vld_in  = r_vld[s-1];
                w_div_in  = r_div[s-1];
                w_side_in = r_side[s-1];
                for (int i = 0; i < 3; i++) begin
                    w_rem_in[i] = r_rem[s-1][i];
                    w_quo_in[i] = r_quo[s-1][i];
                end
            end
        end

        assign w_trial = DVD_W'(w_div_in) << K;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_fit[i] = (w_rem_in[i] >= w_trial);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= w_side_in;
                for (int i = 0; i < 3; i++) begin
                    r_quo[s][i] <= w_fit[i] ? (w_quo_in[i] | (QUO_W'(1) << K)) : w_quo_in[i];
                end
            end
        end

        if (s < QUO_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_div[s] <= w_div_in;
                    for (int i = 0; i < 3; i++) begin
                        r_rem[s][i] <= w_fit[i] ? (w_rem_in[i] - w_trial) : w_rem_in[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_tag <= r_side[QUO_W-1].tag;
            for (int i = 0; i < 3; i++) begin
                if (r_side[QUO_W-1].zero) begin
                    r_o_dir[i] <= '0;
                end else if (r_side[QUO_W-1].neg[i]) begin
                    r_o_dir[i] <= -DIR_W'(r_quo[QUO_W-1][i]);
                end else begin
                    r_o_dir[i] <= DIR_W'(r_quo[QUO_W-1][i]);
                end
            end
        end
    end

    assign o_valid = r_o_vld;
    assign o_dir   = r_o_dir;
    assign o_tag   = r_o_tag;

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QUO_W-1] && !r_side[QUO_W-1].zero |->
            (r_quo[QUO_W-1][0] <= QUO_W'(ONE_Q14)) &&
            (r_quo[QUO_W-1][1] <= QUO_W'(ONE_Q14)) &&
            (r_quo[QUO_W-1][2] <= QUO_W'(ONE_Q14)))
        else $error("direction component above one");

endmodule

### rtl/camera_ray_direction_gen_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_ray_direction_gen_core
// pinhole camera primary ray direction: normalize(corner + right*x/W + down*y/H)
// throughput: one ray per cycle while m_axis is not stalled; a quad input holds
// the input side until the last of its four lanes issues
// the input issue register sets the rate; it emits one lane per enabled cycle
// reset: synchronous active low, clears all valid bits and the three vectors to zero
// ----------------------------------------------------------------------------
module camera_ray_direction_gen_core import crdg_pkg::*; #(
    parameter int FRAME_COLS = 1024,
    parameter int FRAME_ROWS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VEC_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,   // pixel_col, pixel_row
    input  logic                 s_axis_tuser,   // action
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_DATA_W-1:0]  m_axis_tdata,   // dir_x, dir_y, dir_z
    output logic [LANE_W-1:0]    m_axis_tuser,   // lane
    output logic                 m_axis_tlast
);

    logic [VEC_W-1:0] r_corner;
    logic [VEC_W-1:0] r_right;
    logic [VEC_W-1:0] r_down;

    logic                  w_en;
    logic                  w_exp_vld;
    logic [PXW-1:0]        w_px;
    logic [PXW-1:0]        w_py;
    t_tag                  w_exp_tag;
    logic                  w_vec_vld;
    logic [SUM_W-1:0]      w_sum;
    t_carry                w_vec_car;
    logic                  w_sqrt_vld;
    logic [ROOT_W-1:0]     w_root;
    t_carry                w_sqrt_car;
    logic                  w_out_vld;
    logic [2:0][DIR_W-1:0] w_dir;
    t_tag                  w_out_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r_right  <= '0;
            r_down   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CORNER: r_corner <= i_cfg_data;
                CFG_RIGHT:  r_right  <= i_cfg_data;
                CFG_DOWN:   r_down   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en = !w_out_vld || m_axis_tready;

    crdg_expand u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_quad  (s_axis_tuser),
        .i_col   (s_axis_tdata[PIX_W-1:0]),
        .i_row   (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .o_valid (w_exp_vld),
        .o_px    (w_px),
        .o_py    (w_py),
        .o_tag   (w_exp_tag)
    );

    crdg_vec #(
        .FRAME_COLS (FRAME_COLS),
        .FRAME_ROWS (FRAME_ROWS)
    ) u_vec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_exp_vld),
        .i_px     (w_px),
        .i_py     (w_py),
        .i_tag    (w_exp_tag),
        .i_corner (r_corner),
        .i_right  (r_right),
        .i_down   (r_down),
        .o_valid  (w_vec_vld),
        .o_sum    (w_sum),
        .o_carry  (w_vec_car)
    );

    crdg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vec_vld),
        .i_sum   (w_sum),
        .i_carry (w_vec_car),
        .o_valid (w_sqrt_vld),
        .o_root  (w_root),
        .o_carry (w_sqrt_car)
    );

    crdg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sqrt_vld),
        .i_root  (w_root),
        .i_carry (w_sqrt_car),
        .o_valid (w_out_vld),
        .o_dir   (w_dir),
        .o_tag   (w_out_tag)
    );

    assign m_axis_tvalid = w_out_vld;
    assign m_axis_tdata  = {w_dir[2], w_dir[1], w_dir[0]};
    assign m_axis_tuser  = w_out_tag.lane;
    assign m_axis_tlast  = w_out_tag.last;

    a_last_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (m_axis_tuser == '0) || (m_axis_tuser == LANE_FINAL))
        else $error("last ray carries a middle lane");

endmodule
